### hdl/catmull_rom_spline_eval_assert.svh
// ----------------------------------------------------------------------------
// Catmull-Rom spline evaluator: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CATMULL_ROM_SPLINE_EVAL_ASSERT_SVH
`define CATMULL_ROM_SPLINE_EVAL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spline evaluator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CRS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spline evaluator: next-cycle check failed");

`endif

### hdl/crs_pkg.sv
// ----------------------------------------------------------------------------
// Catmull-Rom spline evaluator package
// Sizes, request and status codes, and shared types.
// ----------------------------------------------------------------------------
package crs_pkg;

    // Table and number format
    localparam int MAX_POINTS = 256;
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int T_W        = 24;
    localparam int HELD_W     = 9;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int AXES       = 3;
    localparam int TAPS       = 4;

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int IDX_W  = $clog2(TAPS);
    localparam int INT_W  = T_W - FRAC_BITS;
    localparam int CMP_W  = (CNT_W > INT_W) ? CNT_W + 1 : INT_W + 1;

    // Datapath widths: coefficients reach twelve times a coordinate
    localparam int COEF_W = COORD_W + 4;
    localparam int PROD_W = COEF_W + FRAC_BITS + 1;
    localparam int SUM_W  = COORD_W + 8;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EVAL   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // Control that travels with an item down the pipeline
    typedef struct packed {
        logic                 calc;
        logic                 last;
        logic [STATUS_W-1:0]  status;
        logic [HELD_W-1:0]    held;
        logic [FRAC_BITS-1:0] u;
    } tag_t;

endpackage

### hdl/crs_if.sv
// ----------------------------------------------------------------------------
// Catmull-Rom spline evaluator channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------

// Request channel: append, evaluate or clear
interface crs_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [crs_pkg::REQ_W-1:0]            req_type;
    logic signed [crs_pkg::COORD_W-1:0]   point_x;
    logic signed [crs_pkg::COORD_W-1:0]   point_y;
    logic signed [crs_pkg::COORD_W-1:0]   point_z;
    logic [crs_pkg::T_W-1:0]              t_param;

    modport source (output valid, req_type, point_x, point_y, point_z, t_param,
                    input ready);
    modport sink (input valid, req_type, point_x, point_y, point_z, t_param,
                  output ready);
endinterface

// Result channel: one item per request
interface crs_res_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [crs_pkg::COORD_W-1:0]   pos_x;
    logic signed [crs_pkg::COORD_W-1:0]   pos_y;
    logic signed [crs_pkg::COORD_W-1:0]   pos_z;
    logic [crs_pkg::STATUS_W-1:0]         status;
    logic [crs_pkg::HELD_W-1:0]           points_held;

    modport source (output valid, pos_x, pos_y, pos_z, status, points_held,
                    input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, status, points_held,
                  output ready);
endinterface

### hdl/crs_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per enabled cycle, registered read data.
// ----------------------------------------------------------------------------
module crs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or registered read at one address
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

### hdl/catmull_rom_spline_eval.sv
// ----------------------------------------------------------------------------
// Uniform Catmull-Rom spline evaluator, 3D, signed Q16.16
// Keeps a table of control points and evaluates the spline at a Q8.16
// position from the four neighboring points.
// ----------------------------------------------------------------------------
//
//  Port  | Dir  | Fields                                      | One item is
//  ------+------+---------------------------------------------+----------------
//  cmd   | sink | req_type, point_x/y/z, t_param              | one request
//  res   | src  | pos_x/y/z, status, points_held              | one result
//
// An evaluate reads its four control points one at a time from the
// single-port point table and takes no new request until the last read is
// issued, then passes the read-tag stage, stages 1 to 4 and output register.
// Reset clears the point count and pipeline valids; the table is not cleared
// and needs no sweep, since only entries below the count are ever read.
// Each stage holds only while the stage after it is full, so bubbles close
// up and requests keep entering while a result waits on res.
// ----------------------------------------------------------------------------
`include "catmull_rom_spline_eval_assert.svh"

module catmull_rom_spline_eval (
    input  logic      clk,
    input  logic      rst_n,
    crs_cmd_if.sink   cmd,
    crs_res_if.source res
);

    localparam int FB = crs_pkg::FRAC_BITS;
    localparam logic [crs_pkg::IDX_W-1:0] LAST_IDX  = crs_pkg::IDX_W'(crs_pkg::TAPS - 1);
    localparam logic [crs_pkg::IDX_W-1:0] FIRST_IDX = crs_pkg::IDX_W'(1);
    localparam logic [crs_pkg::CNT_W-1:0] FULL_CNT  = crs_pkg::CNT_W'(crs_pkg::MAX_POINTS);
    localparam logic [crs_pkg::CNT_W-1:0] MIN_CNT   = crs_pkg::CNT_W'(crs_pkg::TAPS);
    localparam logic signed [crs_pkg::SUM_W-1:0] SAT_MAX =
        crs_pkg::SUM_W'({1'b0, {(crs_pkg::COORD_W-1){1'b1}}});
    localparam logic signed [crs_pkg::SUM_W-1:0] SAT_MIN = -SAT_MAX - 1;

    // Stage enables
    logic en_t, en_s1, en_s2, en_s3, en_s4, en_out;

    // Issue control
    logic [crs_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                          busy_reg, busy_next;
    logic [crs_pkg::IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [crs_pkg::ADDR_W-1:0]    seg_reg, seg_next;
    logic [FB-1:0]                 u_reg, u_next;
    logic [crs_pkg::HELD_W-1:0]    held_reg, held_next;
    logic                          accept, full, few;
    logic                          take_append, take_eval, take_clear;
    logic                          issue_vld;
    crs_pkg::tag_t                 issue_tag;
    logic [crs_pkg::CMP_W-1:0]     t_int, seg_lim;
    logic [crs_pkg::ADDR_W-1:0]    seg_calc;
    logic [FB-1:0]                 u_calc;

    // Point table port
    logic                          ram_we;
    logic [crs_pkg::ADDR_W-1:0]    ram_addr;
    crs_pkg::point_t               ram_wdata, ram_rdata;

    // Read-tag stage and point collector
    logic                          t_vld_reg;
    crs_pkg::tag_t                 t_tag_reg;
    crs_pkg::coord_t               rd_lane [crs_pkg::AXES];
    crs_pkg::coord_t               c0_reg [crs_pkg::AXES];
    crs_pkg::coord_t               c1_reg [crs_pkg::AXES];
    crs_pkg::coord_t               c2_reg [crs_pkg::AXES];

    // Stage 1: the four points
    logic                          s1_vld_reg;
    crs_pkg::tag_t                 s1_tag_reg;
    crs_pkg::coord_t               p0_reg [crs_pkg::AXES];
    crs_pkg::coord_t               p1_reg [crs_pkg::AXES];
    crs_pkg::coord_t               p2_reg [crs_pkg::AXES];
    crs_pkg::coord_t               p3_reg [crs_pkg::AXES];

    // Stage 2: coefficients and u^2
    logic                          s2_vld_reg;
    crs_pkg::tag_t                 s2_tag_reg;
    logic signed [crs_pkg::COEF_W-1:0] ca_reg [crs_pkg::AXES];
    logic signed [crs_pkg::COEF_W-1:0] cb_reg [crs_pkg::AXES];
    logic signed [crs_pkg::COEF_W-1:0] cc_reg [crs_pkg::AXES];
    logic signed [crs_pkg::COEF_W-1:0] cd_reg [crs_pkg::AXES];
    logic [FB-1:0]                 u2_reg;
    logic [2*FB-1:0]               uu_prod;

    // Stage 3: b*u, c*u^2, u^3
    logic                          s3_vld_reg;
    crs_pkg::tag_t                 s3_tag_reg;
    logic signed [crs_pkg::COEF_W-1:0] a3_reg [crs_pkg::AXES];
    logic signed [crs_pkg::COEF_W-1:0] d3_reg [crs_pkg::AXES];
    logic signed [crs_pkg::PROD_W-1:0] bu_reg [crs_pkg::AXES];
    logic signed [crs_pkg::PROD_W-1:0] cu_reg [crs_pkg::AXES];
    logic [FB-1:0]                 u3_reg;
    logic [2*FB-1:0]               uuu_prod;
    logic signed [FB:0]            s2_u_s, s2_u2_s, s3_u3_s;

    // Stage 4: d*u^3 and partial sum
    logic                          s4_vld_reg;
    crs_pkg::tag_t                 s4_tag_reg;
    logic signed [crs_pkg::PROD_W-1:0] du_reg [crs_pkg::AXES];
    logic signed [crs_pkg::SUM_W-1:0]  acc_reg [crs_pkg::AXES];

    // Output register
    logic                          res_vld_reg;
    crs_pkg::coord_t               pos_reg [crs_pkg::AXES];
    crs_pkg::coord_t               pos_next [crs_pkg::AXES];
    logic [crs_pkg::STATUS_W-1:0]  status_reg;
    logic [crs_pkg::HELD_W-1:0]    held_out_reg;
    logic signed [crs_pkg::SUM_W-1:0]  sum_full [crs_pkg::AXES];
    logic signed [crs_pkg::SUM_W-1:0]  sum_half [crs_pkg::AXES];

    // Stage enables: a stage loads when it is empty or the next one loads
    assign en_out = !res_vld_reg || res.ready;
    assign en_s4  = !s4_vld_reg || en_out;
    assign en_s3  = !s3_vld_reg || en_s4;
    assign en_s2  = !s2_vld_reg || en_s3;
    assign en_s1  = !s1_vld_reg || en_s2;
    assign en_t   = !t_vld_reg || en_s1;

    assign cmd.ready = en_t && !busy_reg;
    assign accept    = cmd.valid && cmd.ready;
    assign full      = count_reg >= FULL_CNT;
    assign few       = count_reg < MIN_CNT;

    // Accepted request by kind, for the checks at the end
    assign take_append = accept && (cmd.req_type == crs_pkg::REQ_APPEND);
    assign take_eval   = accept && (cmd.req_type == crs_pkg::REQ_EVAL);
    assign take_clear  = accept && (cmd.req_type == crs_pkg::REQ_CLEAR);

    // Clamp the position to the last segment with a fraction of all ones
    always_comb
    begin
        t_int   = crs_pkg::CMP_W'(cmd.t_param[crs_pkg::T_W-1:FB]);
        seg_lim = crs_pkg::CMP_W'(count_reg) - crs_pkg::CMP_W'(crs_pkg::TAPS - 1);
        if (t_int >= seg_lim)
        begin
            seg_calc = crs_pkg::ADDR_W'(seg_lim - crs_pkg::CMP_W'(1));
            u_calc   = '1;
        end
        else
        begin
            seg_calc = crs_pkg::ADDR_W'(t_int);
            u_calc   = cmd.t_param[FB-1:0];
        end
    end

    // Issue: accept a request, or read the remaining control points
    always_comb
    begin
        count_next  = count_reg;
        busy_next   = busy_reg;
        rd_idx_next = rd_idx_reg;
        seg_next    = seg_reg;
        u_next      = u_reg;
        held_next   = held_reg;
        ram_we      = 1'b0;
        ram_addr    = seg_reg + crs_pkg::ADDR_W'(rd_idx_reg);
        ram_wdata   = '{x: cmd.point_x, y: cmd.point_y, z: cmd.point_z};
        issue_vld   = 1'b0;
        issue_tag   = '0;
        issue_tag.u = u_reg;
        if (busy_reg && en_t)
        begin
            issue_vld      = 1'b1;
            issue_tag.calc = 1'b1;
            issue_tag.last = (rd_idx_reg == LAST_IDX);
            issue_tag.held = held_reg;
            rd_idx_next    = rd_idx_reg + crs_pkg::IDX_W'(1);
            if (rd_idx_reg == LAST_IDX)
            begin
                busy_next = 1'b0;
            end
        end
        else if (accept)
        begin
            issue_vld = 1'b1;
            unique case (cmd.req_type)
                crs_pkg::REQ_APPEND:
                begin
                    if (full)
                    begin
                        issue_tag.status = crs_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_addr   = crs_pkg::ADDR_W'(count_reg);
                        count_next = count_reg + crs_pkg::CNT_W'(1);
                    end
                end
                crs_pkg::REQ_EVAL:
                begin
                    if (few)
                    begin
                        issue_tag.status = crs_pkg::ST_FEW;
                    end
                    else
                    begin
                        issue_tag.calc = 1'b1;
                        ram_addr       = seg_calc;
                        seg_next       = seg_calc;
                        u_next         = u_calc;
                        busy_next      = 1'b1;
                        rd_idx_next    = FIRST_IDX;
                        held_next      = crs_pkg::HELD_W'(count_reg);
                    end
                end
                crs_pkg::REQ_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
            issue_tag.held = crs_pkg::HELD_W'(count_next);
        end
    end

    // Issue control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            busy_reg   <= 1'b0;
            rd_idx_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            busy_reg   <= busy_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg  <= seg_next;
        u_reg    <= u_next;
        held_reg <= held_next;
    end

    // Control point table
    crs_ram #(
        .WIDTH ($bits(crs_pkg::point_t)),
        .DEPTH (crs_pkg::MAX_POINTS)
    ) u_point_ram (
        .clk   (clk),
        .en    (en_t),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_lane[0] = ram_rdata.x;
    assign rd_lane[1] = ram_rdata.y;
    assign rd_lane[2] = ram_rdata.z;

    // Pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_vld_reg   <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (en_t)
            begin
                t_vld_reg <= issue_vld;
            end
            if (en_s1)
            begin
                s1_vld_reg <= t_vld_reg && (!t_tag_reg.calc || t_tag_reg.last);
            end
            if (en_s2)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (en_s3)
            begin
                s3_vld_reg <= s2_vld_reg;
            end
            if (en_s4)
            begin
                s4_vld_reg <= s3_vld_reg;
            end
            if (en_out)
            begin
                res_vld_reg <= s4_vld_reg;
            end
        end
    end

    // Read tag follows the table's read latency
    always_ff @(posedge clk)
    begin
        if (en_t)
        begin
            t_tag_reg <= issue_tag;
        end
    end

    // Collect the first three points, then hand all four to stage 1
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < crs_pkg::AXES; k++)
        begin
            if (en_s1 && t_vld_reg && t_tag_reg.calc)
            begin
                c0_reg[k] <= c1_reg[k];
                c1_reg[k] <= c2_reg[k];
                c2_reg[k] <= rd_lane[k];
            end
            if (en_s1)
            begin
                p0_reg[k] <= c0_reg[k];
                p1_reg[k] <= c1_reg[k];
                p2_reg[k] <= c2_reg[k];
                p3_reg[k] <= rd_lane[k];
            end
        end
        if (en_s1)
        begin
            s1_tag_reg <= t_tag_reg;
        end
    end

    // Stage 2: polynomial coefficients and u^2
    assign uu_prod = s1_tag_reg.u * s1_tag_reg.u;

    always_ff @(posedge clk)
    begin
        if (en_s2)
        begin
            for (int k = 0; k < crs_pkg::AXES; k++)
            begin
                ca_reg[k] <= crs_pkg::COEF_W'(p1_reg[k]) <<< 1;
                cb_reg[k] <= crs_pkg::COEF_W'(p2_reg[k]) - crs_pkg::COEF_W'(p0_reg[k]);
                cc_reg[k] <= (crs_pkg::COEF_W'(p0_reg[k]) <<< 1)
                             - (crs_pkg::COEF_W'(p1_reg[k]) <<< 2)
                             - crs_pkg::COEF_W'(p1_reg[k])
                             + (crs_pkg::COEF_W'(p2_reg[k]) <<< 2)
                             - crs_pkg::COEF_W'(p3_reg[k]);
                cd_reg[k] <= crs_pkg::COEF_W'(p1_reg[k])
                             + (crs_pkg::COEF_W'(p1_reg[k]) <<< 1)
                             - crs_pkg::COEF_W'(p2_reg[k])
                             - (crs_pkg::COEF_W'(p2_reg[k]) <<< 1)
                             + crs_pkg::COEF_W'(p3_reg[k])
                             - crs_pkg::COEF_W'(p0_reg[k]);
            end
            u2_reg     <= uu_prod[2*FB-1:FB];
            s2_tag_reg <= s1_tag_reg;
        end
    end

    // Stage 3: b*u, c*u^2 and u^3
    assign s2_u_s   = $signed({1'b0, s2_tag_reg.u});
    assign s2_u2_s  = $signed({1'b0, u2_reg});
    assign uuu_prod = u2_reg * s2_tag_reg.u;

    always_ff @(posedge clk)
    begin
        if (en_s3)
        begin
            for (int k = 0; k < crs_pkg::AXES; k++)
            begin
                bu_reg[k] <= cb_reg[k] * s2_u_s;
                cu_reg[k] <= cc_reg[k] * s2_u2_s;
                a3_reg[k] <= ca_reg[k];
                d3_reg[k] <= cd_reg[k];
            end
            u3_reg     <= uuu_prod[2*FB-1:FB];
            s3_tag_reg <= s2_tag_reg;
        end
    end

    // Stage 4: d*u^3 and the sum of the first three terms
    assign s3_u3_s = $signed({1'b0, u3_reg});

    always_ff @(posedge clk)
    begin
        if (en_s4)
        begin
            for (int k = 0; k < crs_pkg::AXES; k++)
            begin
                du_reg[k]  <= d3_reg[k] * s3_u3_s;
                acc_reg[k] <= crs_pkg::SUM_W'(a3_reg[k])
                              + crs_pkg::SUM_W'(bu_reg[k] >>> FB)
                              + crs_pkg::SUM_W'(cu_reg[k] >>> FB);
            end
            s4_tag_reg <= s3_tag_reg;
        end
    end

    // Final term, halving and saturation; zero unless the item evaluated
    always_comb
    begin
        for (int k = 0; k < crs_pkg::AXES; k++)
        begin
            sum_full[k] = acc_reg[k] + crs_pkg::SUM_W'(du_reg[k] >>> FB);
            sum_half[k] = sum_full[k] >>> 1;
            if (!s4_tag_reg.calc)
            begin
                pos_next[k] = '0;
            end
            else if (sum_half[k] > SAT_MAX)
            begin
                pos_next[k] = crs_pkg::COORD_W'(SAT_MAX);
            end
            else if (sum_half[k] < SAT_MIN)
            begin
                pos_next[k] = crs_pkg::COORD_W'(SAT_MIN);
            end
            else
            begin
                pos_next[k] = crs_pkg::COORD_W'(sum_half[k]);
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            for (int k = 0; k < crs_pkg::AXES; k++)
            begin
                pos_reg[k] <= pos_next[k];
            end
            status_reg   <= s4_tag_reg.status;
            held_out_reg <= s4_tag_reg.held;
        end
    end

    assign res.valid       = res_vld_reg;
    assign res.pos_x       = pos_reg[0];
    assign res.pos_y       = pos_reg[1];
    assign res.pos_z       = pos_reg[2];
    assign res.status      = status_reg;
    assign res.points_held = held_out_reg;

    // Assertions
    `CRS_ASSERT_NXT(a_append_grows, take_append && !full, count_reg == $past(count_reg) + 1'b1)
    `CRS_ASSERT_NXT(a_clear_empties, take_clear, count_reg == '0)
    `CRS_ASSERT_NXT(a_eval_reads, take_eval && !few, busy_reg && (rd_idx_reg == FIRST_IDX))
    `CRS_ASSERT_IMP(a_write_on_accept, ram_we, accept && !busy_reg)
    `CRS_ASSERT_IMP(a_last_read_calc, t_vld_reg && t_tag_reg.last, t_tag_reg.calc)

endmodule
